/* hw/rtl/pfd_pkg.sv */
`timescale 1ns / 1ps

package pfd_pkg;

  // Fixed field widths.
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_BITS = 16;
  localparam int FOLD_BITS = 4;
  localparam int STATUS_BITS = 2;
  localparam int INDEX_BITS = 2;
  localparam int DEF_MAX_STAGES = 12;

  // Register indexes on the write port.
  localparam logic [INDEX_BITS-1:0] REG_FOLD_COUNT = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_SOURCE_LENGTH = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_DEST_LENGTH = 2'd2;

  // Reset values of the registers.
  localparam logic [FOLD_BITS-1:0] RST_FOLD_COUNT = 4'd1;
  localparam logic [LEN_BITS-1:0] RST_SOURCE_LENGTH = 16'd2;
  localparam logic [LEN_BITS-1:0] RST_DEST_LENGTH = 16'd1;

  // Input commands.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_FOLDED = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_PAD = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_REJECT = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic command;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [STATUS_BITS-1:0] status;
    logic is_last;
  } result_t;

  // One beat moving along the chain of stage cells.
  typedef struct packed {
    logic vld;
    logic drain;
    logic [STATUS_BITS-1:0] code;
    logic signed [SAMPLE_BITS-1:0] value;
  } pfd_beat_t;

endpackage

/* hw/rtl/pfd_cell.sv */
`timescale 1ns / 1ps

module pfd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              adv,
  input  logic              active,
  input  pfd_pkg::pfd_beat_t beat_in,
  output pfd_pkg::pfd_beat_t beat_out
);
  import pfd_pkg::*;

  logic pending;
  logic signed [SAMPLE_BITS-1:0] held;
  logic signed [SAMPLE_BITS:0] sum;
  logic folds;

  // Floor of the average: sign-extended sum, then drop the low bit.
  assign sum = {held[SAMPLE_BITS-1], held} + {beat_in.value[SAMPLE_BITS-1], beat_in.value};
  assign folds = beat_in.vld && !beat_in.drain && active;

  // Pending flag, held value and output beat.
  always_ff @(posedge clk) begin
    if (adv) begin
      beat_out.drain <= beat_in.drain;
      beat_out.code <= beat_in.code;
      if (folds) begin
        beat_out.value <= sum[SAMPLE_BITS:1];
        if (!pending) begin
          held <= beat_in.value;
        end
      end else begin
        beat_out.value <= beat_in.value;
      end
    end
    if (rst || clear) begin
      pending <= 1'b0;
      beat_out.vld <= 1'b0;
    end else if (adv) begin
      if (folds) begin
        pending <= !pending;
        beat_out.vld <= pending;
      end else begin
        beat_out.vld <= beat_in.vld;
      end
    end
  end

endmodule

/* hw/rtl/pfd_tail.sv */
`timescale 1ns / 1ps

module pfd_tail (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic [pfd_pkg::LEN_BITS-1:0] dest_length,
  input  pfd_pkg::pfd_beat_t           beat_in,
  input  logic                         result_stall,
  output logic                         result_valid,
  output pfd_pkg::result_t             result,
  output logic                         adv
);
  import pfd_pkg::*;

  logic [LEN_BITS-1:0] results_sent;
  logic [LEN_BITS-1:0] results_sent_next;
  logic [LEN_BITS:0] sent_inc;
  logic hit_last;
  logic done;

  assign adv = !result_valid || !result_stall;
  assign sent_inc = {1'b0, results_sent} + 1'b1;
  assign hit_last = (sent_inc == {1'b0, dest_length});
  assign done = (results_sent >= dest_length);

  // Count results and finish the status of drain beats.
  always_comb begin
    results_sent_next = results_sent;
    if (beat_in.vld) begin
      if (!beat_in.drain || (beat_in.code == ST_PAD && !done)) begin
        results_sent_next = sent_inc[LEN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      results_sent <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      results_sent <= results_sent_next;
      result_valid <= beat_in.vld;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!beat_in.drain) begin
        result.value <= beat_in.value;
        result.status <= ST_FOLDED;
        result.is_last <= hit_last;
      end else if (beat_in.code == ST_PAD && !done) begin
        result.value <= '0;
        result.status <= ST_PAD;
        result.is_last <= hit_last;
      end else if (beat_in.code == ST_PAD) begin
        result.value <= '0;
        result.status <= ST_NONE;
        result.is_last <= 1'b0;
      end else begin
        result.value <= '0;
        result.status <= beat_in.code;
        result.is_last <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/pairwise_fold_decimator.sv */
`timescale 1ns / 1ps
// An item is registered into the first stage cell at the edge that takes it, then passes through
// each further cell in turn and into the output register, from which results are presented.
// Throughput: one item per cycle; the whole chain holds while the output is stalled.
// Reset (rst, synchronous) restores the register defaults and empties the stages;
// any register write also starts a new spectrum.
module pairwise_fold_decimator #(
  parameter int MAX_STAGES = pfd_pkg::DEF_MAX_STAGES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  pfd_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output pfd_pkg::result_t               result,
  input  logic                           wr_en,
  input  logic [pfd_pkg::INDEX_BITS-1:0] wr_index,
  input  logic [pfd_pkg::LEN_BITS-1:0]   wr_data
);
  import pfd_pkg::*;

  logic [FOLD_BITS-1:0] fold_count;
  logic [LEN_BITS-1:0] source_length;
  logic [LEN_BITS-1:0] dest_length;
  logic [LEN_BITS-1:0] samples_taken;
  logic setup_ok;
  logic adv;
  logic accepted;
  logic room;
  pfd_beat_t link [MAX_STAGES+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_count <= RST_FOLD_COUNT;
      source_length <= RST_SOURCE_LENGTH;
      dest_length <= RST_DEST_LENGTH;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FOLD_COUNT: fold_count <= wr_data[FOLD_BITS-1:0];
        REG_SOURCE_LENGTH: source_length <= wr_data;
        REG_DEST_LENGTH: dest_length <= wr_data;
        default: ;
      endcase
    end
  end

  // Setup check.
  always_comb begin
    setup_ok = 1'b1;
    if (source_length <= 16'd1) setup_ok = 1'b0;
    if (dest_length == '0) setup_ok = 1'b0;
    if (dest_length > source_length) setup_ok = 1'b0;
    if (fold_count == '0) setup_ok = 1'b0;
    if ({1'b0, fold_count} > (FOLD_BITS+1)'(MAX_STAGES)) setup_ok = 1'b0;
    if ((source_length >> fold_count) > dest_length) setup_ok = 1'b0;
  end

  // Entry: count samples and classify drain beats.
  assign item_stall = !adv;
  assign accepted = item_valid && adv;
  assign room = samples_taken < source_length;

  always_ff @(posedge clk) begin
    if (rst || wr_en) begin
      samples_taken <= '0;
    end else if (accepted && item.command == CMD_PUSH && setup_ok && room) begin
      samples_taken <= samples_taken + 1'b1;
    end
  end

  always_comb begin
    link[0].vld = accepted && (item.command == CMD_DRAIN || (setup_ok && room));
    link[0].drain = (item.command == CMD_DRAIN);
    link[0].value = item.sample;
    if (!setup_ok) begin
      link[0].code = ST_REJECT;
    end else if (room) begin
      link[0].code = ST_NONE;
    end else begin
      link[0].code = ST_PAD;
    end
  end

  // Chain of halving stages.
  for (genvar s = 0; s < MAX_STAGES; s++) begin : g_stage
    pfd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (wr_en),
      .adv     (adv),
      .active  ({1'b0, fold_count} > (FOLD_BITS+1)'(s)),
      .beat_in (link[s]),
      .beat_out(link[s+1])
    );
  end

  pfd_tail u_tail (
    .clk         (clk),
    .rst         (rst),
    .clear       (wr_en),
    .dest_length (dest_length),
    .beat_in     (link[MAX_STAGES]),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result      (result),
    .adv         (adv)
  );

endmodule
